// ----- design/deq_pkg.sv -----
package deq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ST_W   = 2;

    localparam logic [PTR_W-1:0]  PTR_LAST    = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(DEPTH);
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_SIZE       = 3'd4,
        KIND_EMPTY      = 3'd5,
        KIND_PEEK_FRONT = 3'd6,
        KIND_PEEK_BACK  = 3'd7
    } kind_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

// ----- design/double_ended_queue.sv -----
// Double-ended queue of signed 32-bit values held in a 1024-entry circular buffer.
// Command channel: an operation (kind, push_value) transfers at a rising edge where
// start is high and busy is low. busy never rises, so one operation can issue every
// cycle.
// Result channel: done pulses for one cycle with result_value and status, in the cycle
// after the operation transfers. Pushes that succeed give no result; a push into a
// full queue gives result 0 with the full status. Pops and peeks on an empty queue
// give -1 with the empty status.
// Throughput is one operation per cycle, set by the single-port read of the entry
// memory (registered read data) and the pointer/count update that both finish in
// the transfer cycle.
// A read in one cycle never targets the entry written in the same cycle, so a
// write is already in memory for any later read.
// The receiver cannot stall: a result is gone after its done cycle.
// Reset clears pointers and count (empty queue); memory contents are not cleared
// and need no clearing pass since only live entries are ever read.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               kind,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     done,
    output logic signed [DATA_W-1:0] result_value,
    output logic [ST_W-1:0]          status
);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]  front_reg, front_next;
    logic [PTR_W-1:0]  back_reg, back_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;
    logic              sel_mem_reg, sel_mem_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic              acc;
    logic              is_empty, is_full;
    logic              we, re;
    logic [PTR_W-1:0]  waddr, raddr;
    logic [PTR_W-1:0]  front_inc, front_dec, back_inc, back_dec;
    logic [CNT_W:0]    span_sum;
    logic [PTR_W-1:0]  span_wrap;

    assign busy     = 1'b0;
    assign acc      = start && !busy;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);

    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - 1'b1;
    assign back_inc  = (back_reg == PTR_LAST) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? PTR_LAST : back_reg - 1'b1;

    always_comb
    begin
        front_next   = front_reg;
        back_next    = back_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        sel_mem_next = 1'b0;
        value_next   = '0;
        status_next  = ST_OK;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = back_reg;
        raddr        = front_reg;
        if (acc)
        begin
            case (kind_t'(kind))
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (kind_t'(kind) == KIND_PUSH_FRONT)
                        begin
                            waddr      = front_dec;
                            front_next = front_dec;
                        end
                        else
                        begin
                            waddr     = back_reg;
                            back_next = back_inc;
                        end
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK:
                begin
                    done_next = 1'b1;
                    if (is_empty)
                    begin
                        value_next  = EMPTY_VALUE;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        re           = 1'b1;
                        sel_mem_next = 1'b1;
                        case (kind_t'(kind))
                            KIND_POP_FRONT:
                            begin
                                raddr      = front_reg;
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                            KIND_POP_BACK:
                            begin
                                raddr      = back_dec;
                                back_next  = back_dec;
                                count_next = count_reg - 1'b1;
                            end
                            KIND_PEEK_FRONT: raddr = front_reg;
                            default:         raddr = back_dec;
                        endcase
                    end
                end
                KIND_SIZE:
                begin
                    done_next  = 1'b1;
                    value_next = DATA_W'(count_reg);
                end
                default:
                begin
                    done_next  = 1'b1;
                    value_next = DATA_W'(is_empty);
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= push_value;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg   <= '0;
            back_reg    <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            sel_mem_reg <= 1'b0;
        end
        else
        begin
            front_reg   <= front_next;
            back_reg    <= back_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            sel_mem_reg <= sel_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign result_value = sel_mem_reg ? rd_data_reg : value_reg;
    assign status       = status_reg;

    // front + count wraps onto back
    assign span_sum  = {1'b0, count_reg} + (CNT_W + 1)'(front_reg);
    assign span_wrap = (span_sum >= (CNT_W + 1)'(DEPTH)) ?
                       PTR_W'(span_sum - (CNT_W + 1)'(DEPTH)) : PTR_W'(span_sum);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above depth");

    a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
        span_wrap == back_reg)
        else $error("pointers disagree with entry count");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (kind == KIND_POP_FRONT || kind == KIND_POP_BACK)) |=> done)
        else $error("pop gave no result");

    a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) && !is_full)
        |=> !done)
        else $error("accepted push gave a result");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (result_value == EMPTY_VALUE && !sel_mem_reg))
        else $error("empty status without -1");

endmodule
